[src/nrvs_pkg.sv]
// ----------------------------------------------------------------------------
// nrvs_pkg
// Shared widths, register indexes and controller/datapath types for the
// nearest region voxel search.
// ----------------------------------------------------------------------------
package nrvs_pkg;

  // Field widths.
  localparam int unsigned IdxW    = 10;
  localparam int unsigned ValW    = 16;
  localparam int unsigned OffW    = 24;
  localparam int unsigned SpW     = 16;
  localparam int unsigned PosW    = 27;  // 11-bit signed index times Q7.8 spacing
  localparam int unsigned DiffW   = 28;  // position minus offset
  localparam int unsigned AbsW    = 26;  // magnitude stays below 2^26
  localparam int unsigned SqW     = 52;
  localparam int unsigned DistW   = 54;

  // Ports.
  localparam int unsigned SDataW  = 48;  // 46 bits of fields, padded to bytes
  localparam int unsigned MDataW  = 88;  // 84 bits of fields, padded to bytes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  // Voxels with any index at or beyond this bound are not region voxels.
  localparam int unsigned MaxDim  = 1024;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegTargetOffX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTargetOffY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTargetOffZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSpacingX   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpacingY   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSpacingZ   = 3'd5;

  // Reset values.
  localparam logic signed [OffW-1:0] OffReset = 24'sd0;
  localparam logic signed [SpW-1:0]  SpReset  = 16'sd256;  // 1.0 mm

  // Axis select codes.
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;    // capture the accepted request, clear the accumulator
    logic       pos;     // form |index * spacing - offset| for the selected axis
    logic       sqr;     // square the magnitude
    logic       acc;     // add the square into the distance
    logic       update;  // compare with the best voxel and replace it if nearer
    logic       emit;    // load the result register and clear the best voxel
    logic [1:0] axis;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_region;  // voxel at the input is a region voxel
    logic last_q;     // captured voxel was the last of its volume
    logic out_free;   // result register can take a new result this cycle
  } status_t;

endpackage

[src/nearest_region_voxel_search.sv]
// ----------------------------------------------------------------------------
// nearest_region_voxel_search
// Finds the region voxel nearest to a configured target point in a voxel
// stream and reports it once per volume.
//
//   Channel   Dir  Contents
//   s_axis    in   tdata: col, row, slice, value; tuser: mask; tlast: last
//   m_axis    out  tdata: best col, row, slice, squared distance; tuser: found
//   cfg       in   write enable, register index, write data
//
// A voxel outside the region is taken in the idle state alone; a region voxel
// passes the position, square and accumulate states for each axis through
// the single shared multiply and square path, between its accept and compare
// states. A last voxel hands off the result once the result register is free.
// Reset is asynchronous and active low; it restores the register defaults.
// The input accepts requests while an earlier result waits on the output.
// ----------------------------------------------------------------------------
module nearest_region_voxel_search #(
  parameter int unsigned SDataW = nrvs_pkg::SDataW,
  parameter int unsigned MDataW = nrvs_pkg::MDataW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port.
  input  logic                          cfg_we_i,
  input  logic [nrvs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nrvs_pkg::CfgDatW-1:0]  cfg_wdata_i,
  // Voxel stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // col_index[9:0], row_index[19:10], slice_index[29:20], voxel_value[45:30]
  input  logic [SDataW-1:0]             s_axis_tdata,
  // mask_bit[0]
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tlast,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // best_col[9:0], best_row[19:10], best_slice[29:20], best_dist_sq[83:30]
  output logic [MDataW-1:0]             m_axis_tdata,
  // found[0]
  output logic                          m_axis_tuser
);

  nrvs_pkg::cmd_t    cmd;
  nrvs_pkg::status_t status;

  nrvs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .status_i  (status),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  nrvs_datapath #(
    .SDataW (SDataW),
    .MDataW (MDataW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_data_i    (s_axis_tdata),
    .s_mask_i    (s_axis_tuser),
    .s_last_i    (s_axis_tlast),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_found_o   (m_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

[src/nrvs_ctrl.sv]
// ----------------------------------------------------------------------------
// nrvs_ctrl
// Sequencer for the voxel search: accepts a request, walks the three axes
// through the shared distance unit, compares, and hands off the result.
// ----------------------------------------------------------------------------
module nrvs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  nrvs_pkg::status_t status_i,
  output logic              s_ready_o,
  output nrvs_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPos  = 3'd1;
  localparam logic [2:0] StSqr  = 3'd2;
  localparam logic [2:0] StAcc  = 3'd3;
  localparam logic [2:0] StCmp  = 3'd4;
  localparam logic [2:0] StEmit = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    cmd_o.axis = axis_q;
    case (state_q)
      StIdle: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          axis_d     = nrvs_pkg::AxisX;
          if (status_i.in_region) begin
            state_d = StPos;
          end else if (status_i.last_q) begin
            state_d = StEmit;
          end
        end
      end
      StPos: begin
        cmd_o.pos = 1'b1;
        state_d   = StSqr;
      end
      StSqr: begin
        cmd_o.sqr = 1'b1;
        state_d   = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        if (axis_q == nrvs_pkg::AxisZ) begin
          state_d = StCmp;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = StPos;
        end
      end
      StCmp: begin
        cmd_o.update = 1'b1;
        state_d = status_i.last_q ? StEmit : StIdle;
      end
      StEmit: begin
        // Wait until the result register is free.
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q  <= nrvs_pkg::AxisX;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

endmodule

[src/nrvs_datapath.sv]
// ----------------------------------------------------------------------------
// nrvs_datapath
// Configuration registers, per-axis distance unit, best-voxel registers and
// the result register of the voxel search.
// ----------------------------------------------------------------------------
module nrvs_datapath #(
  parameter int unsigned SDataW = nrvs_pkg::SDataW,
  parameter int unsigned MDataW = nrvs_pkg::MDataW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [nrvs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nrvs_pkg::CfgDatW-1:0]  cfg_wdata_i,
  // Input request fields.
  input  logic [SDataW-1:0]             s_data_i,
  input  logic                          s_mask_i,
  input  logic                          s_last_i,
  // Result channel.
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [MDataW-1:0]             m_data_o,
  output logic                          m_found_o,
  // Controller link.
  input  nrvs_pkg::cmd_t                cmd_i,
  output nrvs_pkg::status_t             status_o
);

  localparam int unsigned IdxW  = nrvs_pkg::IdxW;
  localparam int unsigned DistW = nrvs_pkg::DistW;

  // Configuration registers.
  logic signed [nrvs_pkg::OffW-1:0] off_q [3];
  logic signed [nrvs_pkg::SpW-1:0]  sp_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        off_q[i] <= nrvs_pkg::OffReset;
        sp_q[i]  <= nrvs_pkg::SpReset;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nrvs_pkg::RegTargetOffX: off_q[0] <= cfg_wdata_i;
        nrvs_pkg::RegTargetOffY: off_q[1] <= cfg_wdata_i;
        nrvs_pkg::RegTargetOffZ: off_q[2] <= cfg_wdata_i;
        nrvs_pkg::RegSpacingX:   sp_q[0]  <= cfg_wdata_i[nrvs_pkg::SpW-1:0];
        nrvs_pkg::RegSpacingY:   sp_q[1]  <= cfg_wdata_i[nrvs_pkg::SpW-1:0];
        nrvs_pkg::RegSpacingZ:   sp_q[2]  <= cfg_wdata_i[nrvs_pkg::SpW-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input request.
  logic [IdxW-1:0]           in_col, in_row, in_slc;
  logic [nrvs_pkg::ValW-1:0] in_val;
  logic                      in_range;

  assign in_col = s_data_i[IdxW-1:0];
  assign in_row = s_data_i[2*IdxW-1:IdxW];
  assign in_slc = s_data_i[3*IdxW-1:2*IdxW];
  assign in_val = s_data_i[3*IdxW+nrvs_pkg::ValW-1:3*IdxW];

  assign in_range = (32'(in_col) < nrvs_pkg::MaxDim) &&
                    (32'(in_row) < nrvs_pkg::MaxDim) &&
                    (32'(in_slc) < nrvs_pkg::MaxDim);

  // Captured request.
  logic [IdxW-1:0] col_q, row_q, slc_q;
  logic            last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (cmd_i.load) begin
      last_q <= s_last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= in_col;
      row_q <= in_row;
      slc_q <= in_slc;
    end
  end

  // Axis select for the shared distance unit.
  logic [IdxW-1:0]                  idx_sel;
  logic signed [nrvs_pkg::SpW-1:0]  sp_sel;
  logic signed [nrvs_pkg::OffW-1:0] off_sel;

  always_comb begin
    case (cmd_i.axis)
      nrvs_pkg::AxisX: begin
        idx_sel = col_q;
        sp_sel  = sp_q[0];
        off_sel = off_q[0];
      end
      nrvs_pkg::AxisY: begin
        idx_sel = row_q;
        sp_sel  = sp_q[1];
        off_sel = off_q[1];
      end
      nrvs_pkg::AxisZ: begin
        idx_sel = slc_q;
        sp_sel  = sp_q[2];
        off_sel = off_q[2];
      end
      default: begin
        idx_sel = slc_q;
        sp_sel  = sp_q[2];
        off_sel = off_q[2];
      end
    endcase
  end

  // Axis difference: position in Q.8 minus the target offset.
  logic signed [nrvs_pkg::PosW-1:0]  pos;
  logic signed [nrvs_pkg::DiffW-1:0] diff;
  logic [nrvs_pkg::DiffW-1:0]        diff_mag;

  assign pos      = $signed({1'b0, idx_sel}) * sp_sel;
  assign diff     = nrvs_pkg::DiffW'(pos) - nrvs_pkg::DiffW'(off_sel);
  assign diff_mag = diff[nrvs_pkg::DiffW-1] ? nrvs_pkg::DiffW'(-diff)
                                            : nrvs_pkg::DiffW'(diff);

  // Magnitude, square and running sum.
  logic [nrvs_pkg::AbsW-1:0] abs_q;
  logic [nrvs_pkg::SqW-1:0]  sq_q;
  logic [DistW-1:0]          acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos) begin
      abs_q <= diff_mag[nrvs_pkg::AbsW-1:0];
    end
    if (cmd_i.sqr) begin
      sq_q <= abs_q * abs_q;
    end
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      acc_q <= acc_q + DistW'(sq_q);
    end
  end

  // Nearest voxel so far; the earlier voxel keeps a tie.
  logic             have_q;
  logic [DistW-1:0] best_dist_q;
  logic [IdxW-1:0]  best_col_q, best_row_q, best_slc_q;
  logic             nearer;

  assign nearer = !have_q || (acc_q < best_dist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      best_dist_q <= '0;
      best_col_q  <= '0;
      best_row_q  <= '0;
      best_slc_q  <= '0;
    end else if (cmd_i.emit) begin
      have_q      <= 1'b0;
      best_dist_q <= '0;
      best_col_q  <= '0;
      best_row_q  <= '0;
      best_slc_q  <= '0;
    end else if (cmd_i.update && nearer) begin
      have_q      <= 1'b1;
      best_dist_q <= acc_q;
      best_col_q  <= col_q;
      best_row_q  <= row_q;
      best_slc_q  <= slc_q;
    end
  end

  // Result register; it holds until the downstream side takes it.
  logic              m_valid_q;
  logic [MDataW-1:0] m_data_q;
  logic              m_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_found_q <= have_q;
      m_data_q  <= have_q ? MDataW'({best_dist_q, best_slc_q, best_row_q, best_col_q})
                          : '0;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_found_o = m_found_q;

  // Status to the controller.
  assign status_o.in_region = s_mask_i && (in_val != '0) && in_range;
  assign status_o.last_q    = cmd_i.load ? s_last_i : last_q;
  assign status_o.out_free  = !m_valid_q || m_ready_i;

endmodule

[src/nrvs_checker.sv]
// ----------------------------------------------------------------------------
// nrvs_checker
// Port-level checks on the voxel search, bound to the top level.
// ----------------------------------------------------------------------------
module nrvs_checker #(
  parameter int unsigned SDataW = nrvs_pkg::SDataW,
  parameter int unsigned MDataW = nrvs_pkg::MDataW
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [SDataW-1:0] s_axis_tdata,
  input logic              s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [MDataW-1:0] m_axis_tdata,
  input logic              m_axis_tuser
);

  localparam int unsigned ValLo = 3 * nrvs_pkg::IdxW;
  localparam int unsigned ValHi = ValLo + nrvs_pkg::ValW - 1;

  // A stalled result stays offered.
  a_m_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_m_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // A result without a region voxel carries zero fields.
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("result fields nonzero without a region voxel");

  // A region voxel occupies the distance unit, so the input stalls next cycle.
  a_busy_after_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && (s_axis_tdata[ValHi:ValLo] != '0)
    |=> !s_axis_tready)
    else $error("input ready while a region voxel is in flight");

endmodule

bind nearest_region_voxel_search nrvs_checker #(
  .SDataW (SDataW),
  .MDataW (MDataW)
) u_nrvs_checker (.*);
